FILE: sv/lkvc_pkg.sv
// Shared types and constants for the LRU key-value cache.
// No dependencies; imported by lkvc_table and lru_key_value_cache.
package lkvc_pkg;

  // Table geometry
  localparam int ENTRIES   = 16;
  localparam int KEY_BITS  = 32;
  localparam int DATA_BITS = 32;
  localparam int IDX_W     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int RANK_W    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W     = $clog2(ENTRIES + 1);
  localparam int CAP_W     = 5;

  // Capacity register value after reset
  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(ENTRIES);

  // Request kinds
  localparam logic ACT_GET = 1'b0;
  localparam logic ACT_PUT = 1'b1;

  // One request beat
  typedef struct packed {
    logic                        action;
    logic signed [DATA_BITS-1:0] key;
    logic signed [DATA_BITS-1:0] value;
  } req_t;

  // One result beat
  typedef struct packed {
    logic                        hit;
    logic signed [DATA_BITS-1:0] read_value;
  } rsp_t;

endpackage

FILE: sv/lru_key_value_cache.sv
// LRU key-value cache top level: input register, entry table, result register.
// Depends on lkvc_pkg and lkvc_table.
//
// Usage:
//   Request channel (in_valid / in_stall): in_action 0 is a get, 1 is a put,
//   with in_key and in_value. Result channel (out_valid / out_stall): out_hit
//   tells whether the key was present before the request, out_read_value holds
//   the stored value on a get hit and zero otherwise. One result per request,
//   in request order.
//   Configuration channel (cfg_valid / cfg_ready): cfg_capacity sets how many
//   entries fill before the least recent is evicted; 0 acts as 1, values above
//   16 act as 16. cfg_ready is always high; write only while the block is idle.
// Timing:
//   A request accepted into the input register is looked up and applied once
//   the result register can advance; its result is registered at the same edge
//   as the table update, so one request per cycle is sustained while out_stall
//   is low. A stalled result holds; the input register
//   still accepts a beat behind it, then in_stall rises until the result moves.
// Reset (rst_n low, synchronous): all entries become empty, capacity goes to 16.
module lru_key_value_cache (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic                                  in_action,
  input  logic signed [lkvc_pkg::DATA_BITS-1:0] in_key,
  input  logic signed [lkvc_pkg::DATA_BITS-1:0] in_value,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic                                  out_hit,
  output logic signed [lkvc_pkg::DATA_BITS-1:0] out_read_value,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [lkvc_pkg::CAP_W-1:0]            cfg_capacity
);
  import lkvc_pkg::*;

  logic             req_valid_r;
  req_t             req_r;
  logic             out_valid_r;
  rsp_t             out_rsp_r;
  logic [CAP_W-1:0] capacity_r;
  rsp_t             rsp;
  logic             advance;
  logic             fire;
  logic             in_accept;

  // Handshake
  assign advance   = !out_valid_r || !out_stall;
  assign fire      = req_valid_r && advance;
  assign in_stall  = req_valid_r && !advance;
  assign in_accept = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  // Capacity register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r <= CAP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      capacity_r <= cfg_capacity;
    end
  end

  // Input register: load a new beat, drop it once it fires
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_valid_r <= 1'b0;
    end else if (in_accept) begin
      req_valid_r <= 1'b1;
    end else if (fire) begin
      req_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      req_r.action <= in_action;
      req_r.key    <= in_key;
      req_r.value  <= in_value;
    end
  end

  lkvc_table u_table (
    .clk      (clk),
    .rst_n    (rst_n),
    .fire     (fire),
    .req      (req_r),
    .capacity (capacity_r),
    .rsp      (rsp)
  );

  // Result register: advance when empty or taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= req_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_rsp_r <= rsp;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_hit        = out_rsp_r.hit;
  assign out_read_value = out_rsp_r.read_value;

endmodule

FILE: sv/lkvc_table.sv
// Entry table of the LRU key-value cache: parallel key match, recency ranks,
// eviction choice and state update for one request per cycle while fire is high.
// Depends on lkvc_pkg.
module lkvc_table (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       fire,
  input  lkvc_pkg::req_t             req,
  input  logic [lkvc_pkg::CAP_W-1:0] capacity,
  output lkvc_pkg::rsp_t             rsp
);
  import lkvc_pkg::*;

  logic [ENTRIES-1:0]                valid_r, valid_nxt;
  logic [ENTRIES-1:0][RANK_W-1:0]    rank_r, rank_nxt;
  logic [CNT_W-1:0]                  count_r, count_nxt;
  logic [KEY_BITS-1:0]               key_r   [ENTRIES];
  logic [DATA_BITS-1:0]              value_r [ENTRIES];

  logic [ENTRIES-1:0] hit_vec;
  logic               found;
  logic [IDX_W-1:0]   found_idx;
  logic [RANK_W-1:0]  found_rank;
  logic [CAP_W-1:0]   eff_cap;
  logic               full;
  logic [CNT_W-1:0]   cnt_m1;
  logic [IDX_W-1:0]   victim_idx;
  logic [IDX_W-1:0]   free_idx;
  logic [IDX_W-1:0]   slot;
  logic               put_new;
  logic               evict;

  // Match the key against every valid entry, lowest index wins
  always_comb begin
    found     = 1'b0;
    found_idx = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      hit_vec[i] = valid_r[i] && (key_r[i] == req.key[KEY_BITS-1:0]);
    end
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (hit_vec[i]) begin
        found     = 1'b1;
        found_idx = IDX_W'(i);
      end
    end
  end

  assign found_rank = rank_r[found_idx];

  // Clamp capacity into 1 .. ENTRIES
  always_comb begin
    if (capacity == '0) begin
      eff_cap = CAP_W'(1);
    end else if (capacity > CAP_W'(ENTRIES)) begin
      eff_cap = CAP_W'(ENTRIES);
    end else begin
      eff_cap = capacity;
    end
  end

  assign full   = (count_r >= CNT_W'(eff_cap));
  assign cnt_m1 = count_r - CNT_W'(1);

  // Least recent entry carries the highest rank, count - 1
  always_comb begin
    victim_idx = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (valid_r[i] && (rank_r[i] == cnt_m1[RANK_W-1:0])) begin
        victim_idx = IDX_W'(i);
      end
    end
  end

  // First empty slot
  always_comb begin
    free_idx = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        free_idx = IDX_W'(i);
      end
    end
  end

  assign put_new = (req.action == ACT_PUT) && !found;
  assign evict   = put_new && full;
  assign slot    = evict ? victim_idx : free_idx;

  // Next valid bits, ranks and fill
  always_comb begin
    valid_nxt = valid_r;
    rank_nxt  = rank_r;
    count_nxt = count_r;
    if (fire) begin
      if (found) begin
        // touch: entries more recent than the hit age by one
        for (int i = 0; i < ENTRIES; i++) begin
          if (valid_r[i] && (rank_r[i] < found_rank)) begin
            rank_nxt[i] = rank_r[i] + RANK_W'(1);
          end
        end
        rank_nxt[found_idx] = '0;
      end else if (put_new) begin
        // insert: every entry ages, the new one is most recent
        for (int i = 0; i < ENTRIES; i++) begin
          if (valid_r[i]) begin
            rank_nxt[i] = rank_r[i] + RANK_W'(1);
          end
        end
        valid_nxt[slot] = 1'b1;
        rank_nxt[slot]  = '0;
        if (!evict) begin
          count_nxt = count_r + CNT_W'(1);
        end
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      rank_r  <= '0;
      count_r <= '0;
    end else begin
      valid_r <= valid_nxt;
      rank_r  <= rank_nxt;
      count_r <= count_nxt;
    end
  end

  // Key and value storage
  always_ff @(posedge clk) begin
    if (fire && (req.action == ACT_PUT)) begin
      if (found) begin
        value_r[found_idx] <= req.value;
      end else begin
        key_r[slot]   <= req.key[KEY_BITS-1:0];
        value_r[slot] <= req.value;
      end
    end
  end

  // Result of the request
  always_comb begin
    rsp.hit        = found;
    rsp.read_value = '0;
    if (found && (req.action == ACT_GET)) begin
      rsp.read_value = value_r[found_idx];
    end
  end

endmodule
